// ===== rtl/wht_pkg.sv =====
// shared types, constants and register map of the water heater relay thermostat
`timescale 1ns / 1ps

package wht_pkg;

    localparam int TEMP_W    = 12;
    localparam int TARGET_W  = 10;
    localparam int BAND_W    = 8;
    localparam int STEP_W    = 3;
    localparam int CMP_W     = 13;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 8;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // limits in tenths of a degree
    localparam logic signed [CMP_W-1:0] OVERHEAT_LIMIT = 13'sd850;
    localparam logic signed [CMP_W-1:0] FROST_ON_BELOW = 13'sd40;
    localparam logic signed [CMP_W-1:0] FROST_OFF_AT   = 13'sd50;

    localparam logic [TARGET_W-1:0] TARGET_RESET   = 10'd600;
    localparam logic [BAND_W-1:0]   DEADBAND_RESET = 8'd10;
    localparam logic [BAND_W-1:0]   OVERRUN_RESET  = 8'd10;

    typedef enum logic [1:0] {
        REG_TARGET   = 2'd0,
        REG_DEADBAND = 2'd1,
        REG_OVERRUN  = 2'd2
    } t_reg_idx;

    typedef enum logic [STEP_W-1:0] {
        STEP_ECO        = 3'd1,
        STEP_COMFORT    = 3'd2,
        STEP_BOOST      = 3'd3,
        STEP_ANTIFREEZE = 3'd4
    } t_step;

    typedef enum logic [1:0] {
        ACT_OFF     = 2'd0,
        ACT_IDLE    = 2'd1,
        ACT_HEATING = 2'd2
    } t_action;

    typedef struct packed {
        logic [TARGET_W-1:0] target_temp;
        logic [BAND_W-1:0]   heat_deadband;
        logic [BAND_W-1:0]   heat_overrun;
    } t_cfg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_tenths;
        logic                     temp_valid;
        logic                     heat_enabled;
        logic [STEP_W-1:0]        heat_level;
        logic                     timer_armed;
        logic                     timer_fired;
    } t_item;

    typedef struct packed {
        logic       relay_small;
        logic       relay_large;
        logic [1:0] heat_action;
        logic       action_changed;
        logic       timer_done;
        logic       overheat;
    } t_result;

    typedef struct packed {
        logic [1:0] last_action;
        logic       antifreeze_heating;
    } t_state;

endpackage

// ===== rtl/wht_cfg_regs.sv =====
// apb configuration registers: target, deadband, overrun
`timescale 1ns / 1ps

module wht_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wht_pkg::PADDR_W-1:0] paddr,
    input  logic [wht_pkg::PDATA_W-1:0] pwdata,
    output logic [wht_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output wht_pkg::t_cfg               o_cfg
);
    import wht_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_temp   <= TARGET_RESET;
            r_cfg.heat_deadband <= DEADBAND_RESET;
            r_cfg.heat_overrun  <= OVERRUN_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_TARGET:   r_cfg.target_temp   <= pwdata[TARGET_W-1:0];
                REG_DEADBAND: r_cfg.heat_deadband <= pwdata[BAND_W-1:0];
                REG_OVERRUN:  r_cfg.heat_overrun  <= pwdata[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TARGET:   prdata = {{(PDATA_W-TARGET_W){1'b0}}, r_cfg.target_temp};
            REG_DEADBAND: prdata = {{(PDATA_W-BAND_W){1'b0}}, r_cfg.heat_deadband};
            REG_OVERRUN:  prdata = {{(PDATA_W-BAND_W){1'b0}}, r_cfg.heat_overrun};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/wht_decide.sv =====
// decision logic: overheat, anti-freeze, mode, timer and hysteresis checks
`timescale 1ns / 1ps

module wht_decide (
    input  wht_pkg::t_cfg    i_cfg,
    input  wht_pkg::t_item   i_item,
    input  wht_pkg::t_state  i_state,
    output wht_pkg::t_result o_result,
    output wht_pkg::t_state  o_state
);
    import wht_pkg::*;

    logic signed [CMP_W-1:0] t;
    logic signed [CMP_W-1:0] tgt;
    logic signed [CMP_W-1:0] lo;
    logic signed [CMP_W-1:0] hi;
    logic                    is_af;
    logic                    af;
    logic [1:0]              act;
    logic                    rly_small;
    logic                    rly_large;
    logic                    done;
    logic                    ovh;

    assign t     = CMP_W'(i_item.temp_tenths);
    assign tgt   = $signed({{(CMP_W-TARGET_W){1'b0}}, i_cfg.target_temp});
    assign lo    = tgt - $signed({{(CMP_W-BAND_W){1'b0}}, i_cfg.heat_deadband});
    assign hi    = tgt + $signed({{(CMP_W-BAND_W){1'b0}}, i_cfg.heat_overrun});
    assign is_af = (i_item.heat_level == STEP_ANTIFREEZE);

    always_comb begin
        // latch drops whenever the step is not anti-freeze
        af        = is_af & i_state.antifreeze_heating;
        act       = ACT_OFF;
        rly_small = 1'b0;
        rly_large = 1'b0;
        done      = 1'b0;
        ovh       = 1'b0;
        if (!i_item.temp_valid) begin
            act = ACT_OFF;
        end else if (t > OVERHEAT_LIMIT) begin
            ovh = 1'b1;
            act = ACT_OFF;
        end else if (is_af) begin
            if (!af && t < FROST_ON_BELOW) begin
                af = 1'b1;
            end else if (af && t >= FROST_OFF_AT) begin
                af = 1'b0;
            end
            if (af) begin
                rly_small = 1'b1;
                rly_large = 1'b1;
                act       = ACT_HEATING;
            end else begin
                act = ACT_IDLE;
            end
        end else if (!i_item.heat_enabled) begin
            act = ACT_OFF;
        end else if (i_item.timer_armed) begin
            act = ACT_IDLE;
        end else if (i_item.timer_fired && t >= hi) begin
            done = 1'b1;
            act  = ACT_OFF;
        end else begin
            // hysteresis band holds the previous action
            act = i_state.last_action;
            if (t <= lo) begin
                act = ACT_HEATING;
            end else if (t >= hi) begin
                act = ACT_IDLE;
            end
            if (act == ACT_HEATING) begin
                case (i_item.heat_level)
                    STEP_ECO:     rly_small = 1'b1;
                    STEP_COMFORT: rly_large = 1'b1;
                    STEP_BOOST: begin
                        rly_small = 1'b1;
                        rly_large = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_result.relay_small    = rly_small;
    assign o_result.relay_large    = rly_large;
    assign o_result.heat_action    = act;
    assign o_result.action_changed = (act != i_state.last_action);
    assign o_result.timer_done     = done;
    assign o_result.overheat       = ovh;
    assign o_state.last_action        = act;
    assign o_state.antifreeze_heating = af;

endmodule

// ===== rtl/water_heater_relay_thermostat.sv =====
// top level of the water heater relay thermostat: stream ports, pipeline and state
`timescale 1ns / 1ps

// usage
//   slave stream carries one temperature request per beat; tdata packs from bit 0:
//   temp_tenths[11:0], heat_enabled, heat_level[2:0], timer_armed, timer_fired,
//   zero padding to 24 bits; tuser carries temp_valid
//   master stream returns one result per request; tdata packs from bit 0:
//   relay_small, relay_large, heat_action[1:0], action_changed, timer_done,
//   overheat, one zero pad bit
//   apb port sets target_temp (0x0), heat_deadband (0x4), heat_overrun (0x8);
//   write only while no request is in flight
// timing
//   a request is captured in an input register, decided in one pass of
//   compare-and-select logic, and lands in the output register; one request
//   per cycle is sustained while the receiver does not stall
// reset and stall
//   reset empties both registers, loads the register defaults (60.0 target,
//   1.0 deadband and overrun), and sets the last action to off with the
//   anti-freeze latch clear
//   when the receiver stalls the output holds and the input register still
//   takes one more request before s_axis_tready drops

module water_heater_relay_thermostat (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // temp_tenths[11:0], heat_enabled, heat_level[2:0], timer_armed, timer_fired, pad
    input  logic [wht_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // temp_valid
    input  logic                           s_axis_tuser,
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // relay_small, relay_large, heat_action[1:0], action_changed, timer_done,
    // overheat, pad
    output logic [wht_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // apb configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wht_pkg::PADDR_W-1:0]    paddr,
    input  logic [wht_pkg::PDATA_W-1:0]    pwdata,
    output logic [wht_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import wht_pkg::*;

    t_cfg    cfg;
    t_item   n_item;
    t_item   r_item;
    logic    r_in_valid;
    t_result res;
    t_result r_res;
    logic    r_out_valid;
    t_state  r_state;
    t_state  n_state;
    logic    advance;
    logic    take_in;

    wht_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // unpack the request
    assign n_item.temp_tenths  = $signed(s_axis_tdata[11:0]);
    assign n_item.heat_enabled = s_axis_tdata[12];
    assign n_item.heat_level   = s_axis_tdata[15:13];
    assign n_item.timer_armed  = s_axis_tdata[16];
    assign n_item.timer_fired  = s_axis_tdata[17];
    assign n_item.temp_valid   = s_axis_tuser;

    // move the held request forward when the output register is free or draining
    assign advance       = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | advance;
    assign take_in       = s_axis_tvalid & s_axis_tready;

    wht_decide u_decide (
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_result (res),
        .o_state  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid                 <= 1'b0;
            r_out_valid                <= 1'b0;
            r_state.last_action        <= ACT_OFF;
            r_state.antifreeze_heating <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_item <= n_item;
        end
        if (advance) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_res.overheat, r_res.timer_done, r_res.action_changed,
                            r_res.heat_action, r_res.relay_large, r_res.relay_small};

endmodule

// ===== tb/water_heater_relay_thermostat_tb.sv =====
// self-checking stream testbench of the water heater relay thermostat
`timescale 1ns / 1ps

module water_heater_relay_thermostat_tb;
    import wht_pkg::*;

    // clock, reset and block ports; the driven inputs are known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // temp_tenths[11:0], heat_enabled, heat_level[2:0], timer_armed, timer_fired, pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // temp_valid
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // relay_small, relay_large, heat_action[1:0], action_changed, timer_done, overheat, pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // thermostat state and register copies kept by the testbench
    logic [TARGET_W-1:0] cfg_target = TARGET_RESET;
    logic [BAND_W-1:0]   cfg_deadband = DEADBAND_RESET;
    logic [BAND_W-1:0]   cfg_overrun = OVERRUN_RESET;
    t_action             model_last = ACT_OFF;
    logic                model_frost = 1'b0;

    // relay decisions waiting for their result on the master stream
    t_result expected_relays[$];

    // idling mix, percent of cycles
    int idle_pct = 0;
    int stall_pct = 0;

    int n_mismatch = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_heating = 0;
    int n_timer_done = 0;
    int n_overheat = 0;

    water_heater_relay_thermostat u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // thermostat decision for one accepted request; advances the kept state
    function automatic t_result predict_relays(input t_item req);
        t_result r;
        t_action act;
        int      t;
        int      lo;
        int      hi;
        r  = '0;
        t  = int'(req.temp_tenths);
        lo = int'(cfg_target) - int'(cfg_deadband);
        hi = int'(cfg_target) + int'(cfg_overrun);
        // any step other than anti-freeze drops the frost latch
        if (req.heat_level != STEP_ANTIFREEZE) model_frost = 1'b0;
        if (!req.temp_valid) begin
            act = ACT_OFF;
        end else if (t > OVERHEAT_LIMIT) begin
            r.overheat = 1'b1;
            act = ACT_OFF;
        end else if (req.heat_level == STEP_ANTIFREEZE) begin
            // frost hysteresis: on below 4.0, off at 5.0 and above
            if (!model_frost && t < FROST_ON_BELOW) model_frost = 1'b1;
            else if (model_frost && t >= FROST_OFF_AT) model_frost = 1'b0;
            if (model_frost) begin
                r.relay_small = 1'b1;
                r.relay_large = 1'b1;
                act = ACT_HEATING;
            end else begin
                act = ACT_IDLE;
            end
        end else if (!req.heat_enabled) begin
            act = ACT_OFF;
        end else if (req.timer_armed) begin
            act = ACT_IDLE;
        end else if (req.timer_fired && t >= hi) begin
            r.timer_done = 1'b1;
            act = ACT_OFF;
        end else begin
            // inside the band the previous action holds, off included
            act = model_last;
            if (t <= lo) act = ACT_HEATING;
            else if (t >= hi) act = ACT_IDLE;
            if (act == ACT_HEATING) begin
                case (req.heat_level)
                    STEP_ECO:     r.relay_small = 1'b1;
                    STEP_COMFORT: r.relay_large = 1'b1;
                    STEP_BOOST: begin
                        r.relay_small = 1'b1;
                        r.relay_large = 1'b1;
                    end
                    default: ;  // undefined step: relays stay off
                endcase
            end
        end
        r.heat_action    = act;
        r.action_changed = (act != model_last);
        model_last = act;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_mismatch++;
        if (n_mismatch <= 40) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [1:0] got,
                               input logic [1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      n_results, name, got, want));
    endtask

    // request capture and result checking, both at the rising edge
    always @(posedge i_clk) begin : monitor
        t_item   req;
        t_result want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            req.temp_tenths  = s_axis_tdata[11:0];
            req.heat_enabled = s_axis_tdata[12];
            req.heat_level   = s_axis_tdata[15:13];
            req.timer_armed  = s_axis_tdata[16];
            req.timer_fired  = s_axis_tdata[17];
            req.temp_valid   = s_axis_tuser;
            expected_relays.push_back(predict_relays(req));
            n_requests++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (expected_relays.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = expected_relays.pop_front();
                check_field("relay_small", 2'(m_axis_tdata[0]), 2'(want.relay_small));
                check_field("relay_large", 2'(m_axis_tdata[1]), 2'(want.relay_large));
                check_field("heat_action", m_axis_tdata[3:2], want.heat_action);
                check_field("action_changed", 2'(m_axis_tdata[4]),
                            2'(want.action_changed));
                check_field("timer_done", 2'(m_axis_tdata[5]), 2'(want.timer_done));
                check_field("overheat", 2'(m_axis_tdata[6]), 2'(want.overheat));
                if (want.heat_action == ACT_HEATING) n_heating++;
                if (want.timer_done) n_timer_done++;
                if (want.overheat) n_overheat++;
            end
        end
    end

    // one request on the slave stream, with a random lead-in gap
    task automatic send_request(input t_item req);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, req.timer_fired, req.timer_armed, req.heat_level,
                          req.heat_enabled, req.temp_tenths};
        s_axis_tuser  <= req.temp_valid;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_until_drained;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_relays.size() != 0) @(posedge i_clk);
        // two-stage pipeline: let it settle before touching registers
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        // pready is tied high, so the access completes at this edge
        @(posedge i_clk);
        case (idx)
            REG_TARGET:   cfg_target   = value[TARGET_W-1:0];
            REG_DEADBAND: cfg_deadband = value[BAND_W-1:0];
            REG_OVERRUN:  cfg_overrun  = value[BAND_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int target, input int deadband, input int overrun);
        write_reg(REG_TARGET, target);
        write_reg(REG_DEADBAND, deadband);
        write_reg(REG_OVERRUN, overrun);
    endtask

    function automatic t_item mk_request(input int temp, input bit valid, input bit enabled,
                                         input logic [STEP_W-1:0] step, input bit armed,
                                         input bit fired);
        t_item req;
        req.temp_tenths  = temp[TEMP_W-1:0];
        req.temp_valid   = valid;
        req.heat_enabled = enabled;
        req.heat_level   = step;
        req.timer_armed  = armed;
        req.timer_fired  = fired;
        return req;
    endfunction

    // sessions of steady mode with a slowly drifting temperature, so the
    // hysteresis edges are crossed in both directions; some raw noise mixed in
    task automatic run_sessions(input int n_items);
        int    left;
        int    len;
        int    temp;
        t_item mode;
        t_item req;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(4, 40);
            case ($urandom_range(5))
                0: temp = int'(cfg_target) - int'(cfg_deadband);
                1: temp = int'(cfg_target) + int'(cfg_overrun);
                2: temp = 45;
                3: temp = 850;
                4: temp = int'($urandom_range(0, 1650)) - 400;
                default: temp = int'(cfg_target);
            endcase
            temp = temp + int'($urandom_range(0, 60)) - 30;
            mode = mk_request(0, 1'b1, $urandom_range(9) != 0,
                              ($urandom_range(9) == 0) ? 3'($urandom_range(0, 7))
                                                       : 3'($urandom_range(1, 4)),
                              $urandom_range(9) == 0, $urandom_range(3) == 0);
            for (int i = 0; i < len && left > 0; i++) begin
                if ($urandom_range(19) == 0) begin
                    // noise: every field drawn over its full width
                    req = mk_request($urandom_range(0, 4095), 1'($urandom_range(1)),
                                     1'($urandom_range(1)), 3'($urandom_range(0, 7)),
                                     1'($urandom_range(1)), 1'($urandom_range(1)));
                end else begin
                    temp = temp + int'($urandom_range(0, 16)) - 8;
                    if (temp < -400) temp = -400;
                    if (temp > 1250) temp = 1250;
                    req = mode;
                    req.temp_tenths = temp[TEMP_W-1:0];
                    req.temp_valid  = ($urandom_range(29) != 0);
                end
                send_request(req);
                left--;
            end
        end
    endtask

    // corner cases at the reset settings: target 60.0, band 59.0 .. 61.0
    task automatic test_directed;
        idle_pct  = 0;
        stall_pct = 0;
        send_request(mk_request(500, 1'b0, 1'b1, STEP_ECO, 1'b0, 1'b0));   // invalid sample
        send_request(mk_request(-400, 1'b1, 1'b1, STEP_ECO, 1'b0, 1'b0));  // coldest, heat eco
        send_request(mk_request(600, 1'b1, 1'b1, STEP_COMFORT, 1'b0, 1'b0));  // band holds heat
        send_request(mk_request(610, 1'b1, 1'b1, STEP_BOOST, 1'b0, 1'b0)); // overrun reached
        send_request(mk_request(595, 1'b1, 1'b1, STEP_ECO, 1'b0, 1'b0));   // band holds idle
        send_request(mk_request(590, 1'b1, 1'b1, STEP_BOOST, 1'b0, 1'b0)); // deadband, both on
        // undefined steps keep the action but leave the relays off
        send_request(mk_request(600, 1'b1, 1'b1, 3'd0, 1'b0, 1'b0));
        send_request(mk_request(600, 1'b1, 1'b1, 3'd5, 1'b0, 1'b0));
        send_request(mk_request(600, 1'b1, 1'b1, 3'd6, 1'b0, 1'b0));
        send_request(mk_request(600, 1'b1, 1'b1, 3'd7, 1'b0, 1'b0));
        send_request(mk_request(851, 1'b1, 1'b1, STEP_ECO, 1'b0, 1'b0));  // just over the limit
        send_request(mk_request(850, 1'b1, 1'b1, STEP_ECO, 1'b0, 1'b0));  // at the limit, idle
        send_request(mk_request(1250, 1'b1, 1'b1, STEP_BOOST, 1'b0, 1'b0));
        send_request(mk_request(600, 1'b1, 1'b0, STEP_ECO, 1'b0, 1'b0));  // off mode
        send_request(mk_request(600, 1'b1, 1'b1, STEP_ECO, 1'b1, 1'b0));  // timer armed
        send_request(mk_request(610, 1'b1, 1'b1, STEP_ECO, 1'b0, 1'b1));  // timer done
        send_request(mk_request(600, 1'b1, 1'b1, STEP_ECO, 1'b0, 1'b1));  // fired, below stop
        // anti-freeze latch: on below 4.0, off at 5.0
        send_request(mk_request(45, 1'b1, 1'b1, STEP_ANTIFREEZE, 1'b0, 1'b0));
        send_request(mk_request(39, 1'b1, 1'b1, STEP_ANTIFREEZE, 1'b0, 1'b0));
        send_request(mk_request(49, 1'b1, 1'b1, STEP_ANTIFREEZE, 1'b0, 1'b0));
        send_request(mk_request(50, 1'b1, 1'b1, STEP_ANTIFREEZE, 1'b0, 1'b0));
        send_request(mk_request(39, 1'b1, 1'b0, STEP_ANTIFREEZE, 1'b0, 1'b0));  // beats off mode
        send_request(mk_request(39, 1'b0, 1'b1, STEP_ANTIFREEZE, 1'b0, 1'b0));  // latch kept
        send_request(mk_request(45, 1'b1, 1'b1, STEP_ANTIFREEZE, 1'b0, 1'b0));
        send_request(mk_request(45, 1'b1, 1'b1, STEP_ECO, 1'b0, 1'b0));  // leaving clears latch
        send_request(mk_request(45, 1'b1, 1'b1, STEP_ANTIFREEZE, 1'b0, 1'b0));
        // raw extremes of the 12-bit sample
        send_request(mk_request(-2048, 1'b1, 1'b1, STEP_ECO, 1'b0, 1'b0));
        send_request(mk_request(2047, 1'b1, 1'b1, STEP_ECO, 1'b0, 1'b0));
        wait_until_drained;
    endtask

    // register extremes, each with a short burst around the new thresholds
    task automatic test_register_extremes;
        int settings[6][3] = '{'{0, 0, 0}, '{1000, 200, 200}, '{1023, 255, 255},
                               '{0, 200, 200}, '{1000, 0, 0}, '{600, 10, 10}};
        idle_pct  = 17;
        stall_pct = 17;
        foreach (settings[i]) begin
            set_config(settings[i][0], settings[i][1], settings[i][2]);
            run_sessions(30);
            wait_until_drained;
        end
    endtask

    // bulk random traffic under each idling mix, with a full drain mid-phase
    task automatic test_idle_mixes;
        int sender_mix[4]   = '{0, 77, 0, 17};
        int receiver_mix[4] = '{0, 0, 77, 17};
        foreach (sender_mix[p]) begin
            idle_pct  = sender_mix[p];
            stall_pct = receiver_mix[p];
            set_config($urandom_range(0, 1000), $urandom_range(0, 200),
                       $urandom_range(0, 200));
            run_sessions(160);
            wait_until_drained;
            run_sessions(160);
            wait_until_drained;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed;
        test_register_extremes;
        test_idle_mixes;
        wait_until_drained;

        if (expected_relays.size() != 0) report_mismatch("results still outstanding at end");
        $display("covered %0d requests, %0d results, %0d register writes, four idle mixes",
                 n_requests, n_results, n_writes);
        $display("seen %0d heating, %0d timer completions, %0d overheat results",
                 n_heating, n_timer_done, n_overheat);
        if (n_mismatch == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_relays.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
